[rtl/shared_buffer_multi_queue_assert.svh]
// Assertion macros for the shared buffer multi-queue block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SBMQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SBMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sbmq_pkg.sv]
// Package for the shared buffer multi-queue block: sizes, codes, state and
// control/status types. No dependencies.
`default_nettype none

package sbmq_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_QUEUES  = 4;

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int PTR_W  = $clog2(NUM_ENTRIES + 1);
    localparam int QID_W  = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_ENTRIES);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVER  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDER = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ENQ_TAKE,
        S_ENQ_LINK,
        S_DEQ_STEP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic enq_take;
        logic enq_link;
        logic deq_step;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic cmd_deq;
        logic free_empty;
        logic queue_empty;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/sbmq_ctrl.sv]
// Sequencer for the shared buffer multi-queue block.
// Depends on sbmq_pkg; drives commands into sbmq_datapath.
`default_nettype none

module sbmq_ctrl
    import sbmq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output ctrl_t      ctrl,
    output state_t     state
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.cmd_deq)
                begin
                    state_next = stat.queue_empty ? S_RESP : S_DEQ_STEP;
                end
                else
                begin
                    state_next = stat.free_empty ? S_RESP : S_ENQ_TAKE;
                end
            end
            S_ENQ_TAKE: state_next = S_ENQ_LINK;
            S_ENQ_LINK: state_next = S_RESP;
            S_DEQ_STEP: state_next = S_RESP;
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            S_DECIDE:   ctrl.decide   = 1'b1;
            S_ENQ_TAKE: ctrl.enq_take = 1'b1;
            S_ENQ_LINK: ctrl.enq_link = 1'b1;
            S_DEQ_STEP: ctrl.deq_step = 1'b1;
            S_RESP:     ctrl.out_load = stat.out_free;
            default:    ctrl          = '0;
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

[rtl/sbmq_datapath.sv]
// Datapath: link table, data store, queue pointers, free list, output register.
// Depends on sbmq_pkg; steered by sbmq_ctrl.
`default_nettype none

module sbmq_datapath
    import sbmq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_t             ctrl,
    output stat_t                  stat,
    input  wire logic              in_cmd,
    input  wire logic [QID_W-1:0]  in_qid,
    input  wire logic [DATA_W-1:0] in_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAT_W-1:0]      out_status,
    output logic [DATA_W-1:0]      out_data
);

    logic                  cmd_reg;
    logic [QID_W-1:0]      qid_reg;
    logic [DATA_W-1:0]     value_reg;
    logic [STAT_W-1:0]     res_status_reg;
    logic [IDX_W-1:0]      ent_reg;
    logic [DATA_W-1:0]     rd_data_reg;

    logic [PTR_W-1:0]      free_head_reg;
    logic [PTR_W-1:0]      queue_head_reg [NUM_QUEUES];
    logic [IDX_W-1:0]      queue_tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0]      link_reg       [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] link_vld_reg;
    logic [DATA_W-1:0]     data_mem       [NUM_ENTRIES];

    logic                  out_valid_reg;
    logic [STAT_W-1:0]     out_status_reg;
    logic [DATA_W-1:0]     out_data_reg;

    logic [PTR_W-1:0]      qhead;
    logic [IDX_W-1:0]      rd_idx;
    logic [PTR_W-1:0]      link_rd;
    logic                  free_empty;
    logic                  queue_empty;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [PTR_W-1:0]      link_wdata;

    assign qhead       = queue_head_reg[qid_reg];
    assign free_empty  = (free_head_reg >= NIL);
    assign queue_empty = (qhead >= NIL);

    // link read port; entries never written read their chained reset value
    assign rd_idx = ctrl.deq_step ? qhead[IDX_W-1:0] : free_head_reg[IDX_W-1:0];

    always_comb
    begin
        if (link_vld_reg[rd_idx])
        begin
            link_rd = link_reg[rd_idx];
        end
        else if (rd_idx == IDX_W'(NUM_ENTRIES - 1))
        begin
            link_rd = NIL;
        end
        else
        begin
            link_rd = PTR_W'(rd_idx) + PTR_W'(1);
        end
    end

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = rd_idx;
        link_wdata = NIL;
        if (ctrl.enq_take)
        begin
            link_we = 1'b1;
        end
        else if (ctrl.enq_link && !queue_empty)
        begin
            link_we    = 1'b1;
            link_waddr = queue_tail_reg[qid_reg];
            link_wdata = PTR_W'(ent_reg);
        end
        else if (ctrl.deq_step)
        begin
            link_we    = 1'b1;
            link_wdata = free_head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_reg[link_waddr] <= link_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else if (link_we)
        begin
            link_vld_reg[link_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.enq_take)
        begin
            data_mem[rd_idx] <= value_reg;
        end
        if (ctrl.deq_step)
        begin
            rd_data_reg <= data_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                queue_head_reg[i] <= NIL;
            end
        end
        else
        begin
            if (ctrl.enq_take)
            begin
                free_head_reg <= link_rd;
            end
            else if (ctrl.deq_step)
            begin
                free_head_reg <= qhead;
            end
            if (ctrl.enq_link && queue_empty)
            begin
                queue_head_reg[qid_reg] <= PTR_W'(ent_reg);
            end
            else if (ctrl.deq_step)
            begin
                queue_head_reg[qid_reg] <= link_rd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.enq_link)
        begin
            queue_tail_reg[qid_reg] <= ent_reg;
        end
        if (ctrl.enq_take)
        begin
            ent_reg <= rd_idx;
        end
        if (ctrl.load)
        begin
            cmd_reg   <= in_cmd;
            qid_reg   <= in_qid;
            value_reg <= in_value;
        end
        if (ctrl.decide)
        begin
            if (cmd_reg == CMD_DEQ)
            begin
                res_status_reg <= queue_empty ? STAT_UNDER : STAT_DONE;
            end
            else
            begin
                res_status_reg <= free_empty ? STAT_OVER : STAT_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_status_reg <= res_status_reg;
            if (cmd_reg == CMD_DEQ && res_status_reg == STAT_DONE)
            begin
                out_data_reg <= rd_data_reg;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign stat.cmd_deq     = (cmd_reg == CMD_DEQ);
    assign stat.free_empty  = free_empty;
    assign stat.queue_empty = queue_empty;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;

endmodule

`default_nettype wire

[rtl/shared_buffer_multi_queue.sv]
// Channel  Dir  tdata             tuser
// s_axis   in   value[31:0]       cmd[0], queue_id[2:1]
// m_axis   out  data_out[31:0]    status[1:0]
//
// One operation at a time: accept, decide, then none, one or two table steps,
// then the result register. Enqueue takes two link-table steps and dequeue one,
// as the link table has a single write port; an overflow or underflow takes none.
// rst_n clears the free list to entry 0 and empties every queue at once.
// A result waiting on m_axis_tready stalls only the final step; the next beat
// is accepted while the previous result is still held.
`default_nettype none
`include "shared_buffer_multi_queue_assert.svh"

module shared_buffer_multi_queue
    import sbmq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value[31:0]
    input  wire logic [2:0]  s_axis_tuser,   // cmd[0], queue_id[2:1]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // data_out[31:0]
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    ctrl_t  ctrl;
    stat_t  stat;
    state_t state;

    sbmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl),
        .state    (state)
    );

    sbmq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_cmd     (s_axis_tuser[0]),
        .in_qid     (s_axis_tuser[2:1]),
        .in_value   (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata)
    );

    `SBMQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted a beat while busy")
    `SBMQ_ASSERT_SAME(a_no_result_overwrite, ctrl.out_load, !m_axis_tvalid || m_axis_tready, "result overwritten before taken")
    `SBMQ_ASSERT_SAME(a_error_data_zero, m_axis_tvalid && m_axis_tuser != STAT_DONE, m_axis_tdata == '0, "nonzero data on error result")
    `SBMQ_ASSERT_NEXT(a_take_then_link, state == S_ENQ_TAKE, state == S_ENQ_LINK, "enqueue sequence broken")

endmodule

`default_nettype wire
